FILE: src/psqm_pkg.sv
// ----------------------------------------------------------------------------
// psqm_pkg: shared types and codes of the process state queue manager
// Request and result layouts, event codes, status codes and queue ids.
// ----------------------------------------------------------------------------
package psqm_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int REC_W = 48;

  typedef enum logic [2:0] {
    REQ_ADMIT    = 3'd0,
    REQ_DISPATCH = 3'd1,
    REQ_QUANTUM  = 3'd2,
    REQ_EXIT     = 3'd3,
    REQ_BLOCK    = 3'd4,
    REQ_UNBLOCK  = 3'd5
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    Q_NEW     = 2'd0,
    Q_RUNNING = 2'd1,
    Q_WAITING = 2'd2,
    Q_DONE    = 2'd3
  } queue_id_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] pid;
    logic [7:0] psw;
    logic [7:0] pt_byte;
    logic [7:0] reg_zero;
    logic [7:0] reg_one;
    logic [7:0] reg_two;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] moved_pid;
    logic [7:0] moved_psw;
    logic [7:0] moved_pt_byte;
    logic [7:0] moved_reg_zero;
    logic [7:0] moved_reg_one;
    logic [7:0] moved_reg_two;
    logic [4:0] new_count;
    logic [4:0] running_count;
    logic [4:0] waiting_count;
    logic [4:0] done_count;
  } result_t;

endpackage

FILE: src/psqm_ram.sv
// ----------------------------------------------------------------------------
// psqm_ram: record store of one queue
// Single port memory: reads each cycle, writes on we, registered read data.
// ----------------------------------------------------------------------------
module psqm_ram
  import psqm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [REC_W-1:0] wdata,
  output logic [REC_W-1:0] rdata
);

  logic [REC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/process_state_queue_manager.sv
// ----------------------------------------------------------------------------
// process_state_queue_manager: four FIFO queues of process records
// A sequencer moves records between the new, running, waiting and done
// queues through one shared slot address unit and four record memories.
// ----------------------------------------------------------------------------
//   channel   | ports                  | handshake
//   request   | start, busy, request   | taken when start is high and busy low
//   result    | done, result           | one cycle per item, done marks it
//
// Admit and failed events pass from check to done; moves add a read and a write.
// Unblock scans waiting with a read and a compare per entry, then closes the
// gap with a read and a write per later entry.
// Reset empties all queues at once; the memories need no clearing.
// busy stays high until the cycle after done; results cannot be stalled.
module process_state_queue_manager
  import psqm_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_CHECK    = 10'b0000000010,
    S_MOVE_RD  = 10'b0000000100,
    S_MOVE_WR  = 10'b0000001000,
    S_SCAN_RD  = 10'b0000010000,
    S_SCAN_CMP = 10'b0000100000,
    S_SH_RD    = 10'b0001000000,
    S_SH_WR    = 10'b0010000000,
    S_UB_WR    = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t           state;
  request_t         req;
  logic [REC_W-1:0] rec;
  status_t          status;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    cnt  [4];
  logic [AW-1:0]    head [4];
  queue_id_t        rd_q;

  queue_id_t        src_q, dst_q, sel_q;
  logic [CW-1:0]    sel_off;
  logic [AW:0]      slot_sum;
  logic [AW-1:0]    slot;
  logic             wr_en;
  logic [REC_W-1:0] wr_data;
  logic [REC_W-1:0] rd_data [4];
  logic [REC_W-1:0] rdata;
  logic [REC_W-1:0] in_rec;
  logic [CW-1:0]    idx_inc;

  assign in_rec  = {req.reg_two, req.reg_one, req.reg_zero,
                    req.pt_byte, req.psw, req.pid};
  assign idx_inc = idx + CW'(1);

  always_comb begin
    unique case (req.req_type)
      REQ_DISPATCH: begin src_q = Q_NEW;     dst_q = Q_RUNNING; end
      REQ_QUANTUM:  begin src_q = Q_RUNNING; dst_q = Q_NEW;     end
      REQ_EXIT:     begin src_q = Q_RUNNING; dst_q = Q_DONE;    end
      REQ_BLOCK:    begin src_q = Q_RUNNING; dst_q = Q_WAITING; end
      default:      begin src_q = Q_WAITING; dst_q = Q_NEW;     end
    endcase
  end

  // Shared slot unit: picks a queue and an offset from its head each cycle.
  always_comb begin
    sel_q   = Q_NEW;
    sel_off = cnt[Q_NEW];
    wr_en   = 1'b0;
    wr_data = rdata;
    unique case (state)
      S_CHECK: begin
        wr_en   = (req.req_type == REQ_ADMIT) && (cnt[Q_NEW] != CW'(QUEUE_DEPTH));
        wr_data = in_rec;
      end
      S_MOVE_RD: begin
        sel_q   = src_q;
        sel_off = '0;
      end
      S_MOVE_WR: begin
        sel_q   = dst_q;
        sel_off = cnt[dst_q];
        wr_en   = 1'b1;
      end
      S_SCAN_RD, S_SCAN_CMP: begin
        sel_q   = Q_WAITING;
        sel_off = idx;
      end
      S_SH_RD: begin
        sel_q   = Q_WAITING;
        sel_off = idx_inc;
      end
      S_SH_WR: begin
        sel_q   = Q_WAITING;
        sel_off = idx;
        wr_en   = 1'b1;
      end
      S_UB_WR: begin
        wr_en   = 1'b1;
        wr_data = rec;
      end
      default: ;
    endcase
  end

  assign slot_sum = {1'b0, head[sel_q]} + {1'b0, sel_off[AW-1:0]};
  assign slot = (slot_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                AW'(slot_sum - (AW+1)'(QUEUE_DEPTH)) : slot_sum[AW-1:0];

  for (genvar q = 0; q < 4; q++) begin : g_store
    psqm_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
      .clk   (clk),
      .we    (wr_en && (sel_q == queue_id_t'(q))),
      .addr  (slot),
      .wdata (wr_data),
      .rdata (rd_data[q])
    );
  end

  assign rdata = rd_data[rd_q];

  always_ff @(posedge clk) begin
    rd_q <= sel_q;
    if (rst) begin
      state <= S_IDLE;
      for (int q = 0; q < 4; q++) begin
        cnt[q]  <= '0;
        head[q] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req    <= request;
            rec    <= '0;
            status <= ST_OK;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          unique case (req.req_type)
            REQ_ADMIT: begin
              state <= S_DONE;
              if (cnt[Q_NEW] == CW'(QUEUE_DEPTH)) begin
                status <= ST_FULL;
              end else begin
                rec        <= in_rec;
                cnt[Q_NEW] <= cnt[Q_NEW] + CW'(1);
              end
            end
            REQ_DISPATCH, REQ_QUANTUM, REQ_EXIT, REQ_BLOCK, REQ_UNBLOCK: begin
              idx <= '0;
              if (cnt[src_q] == '0) begin
                status <= ST_EMPTY;
                state  <= S_DONE;
              end else if (cnt[dst_q] == CW'(QUEUE_DEPTH)) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else begin
                state <= (req.req_type == REQ_UNBLOCK) ? S_SCAN_RD : S_MOVE_RD;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_MOVE_RD: begin
          head[src_q] <= (head[src_q] == AW'(QUEUE_DEPTH - 1)) ? '0 :
                         head[src_q] + AW'(1);
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          rec        <= rdata;
          cnt[src_q] <= cnt[src_q] - CW'(1);
          cnt[dst_q] <= cnt[dst_q] + CW'(1);
          state      <= S_DONE;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (rdata[7:0] == req.pid) begin
            rec   <= rdata;
            state <= S_SH_RD;
          end else if (idx_inc == cnt[Q_WAITING]) begin
            status <= ST_NOT_FOUND;
            state  <= S_DONE;
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN_RD;
          end
        end
        S_SH_RD: begin
          // Later entries move up by one so the waiting order is kept.
          state <= (idx_inc < cnt[Q_WAITING]) ? S_SH_WR : S_UB_WR;
        end
        S_SH_WR: begin
          idx   <= idx_inc;
          state <= S_SH_RD;
        end
        S_UB_WR: begin
          cnt[Q_NEW]     <= cnt[Q_NEW] + CW'(1);
          cnt[Q_WAITING] <= cnt[Q_WAITING] - CW'(1);
          state          <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    result.status           = status;
    result.moved_pid        = rec[7:0];
    result.moved_psw        = rec[15:8];
    result.moved_pt_byte    = rec[23:16];
    result.moved_reg_zero   = rec[31:24];
    result.moved_reg_one    = rec[39:32];
    result.moved_reg_two    = rec[47:40];
    result.new_count        = 5'(cnt[Q_NEW]);
    result.running_count    = 5'(cnt[Q_RUNNING]);
    result.waiting_count    = 5'(cnt[Q_WAITING]);
    result.done_count       = 5'(cnt[Q_DONE]);
  end

endmodule

FILE: src/psqm_checker.sv
// ----------------------------------------------------------------------------
// psqm_checker: port level checks of the process state queue manager
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module psqm_checker
  import psqm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input result_t  result
);

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after start");

  // A result only comes out while an item is in work.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without busy");

  // The block frees up right after its result.
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy held after done");

  // A failed event shows an all zero record; its pid and reg_two bytes are checked.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_OK)) |->
      (result.moved_pid == 8'd0 && result.moved_reg_two == 8'd0))
    else $error("record not cleared on failed event");

endmodule

bind process_state_queue_manager psqm_checker u_psqm_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);
